// ===== rtl/bmf_pkg.sv =====
package bmf_pkg;

  localparam int SE_MAX     = 5;
  localparam int MASK_W     = SE_MAX * SE_MAX;
  localparam int MODE_W     = 2;
  localparam int DIM_W      = 3;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 25;
  localparam int QDEPTH     = 4;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 4'd0,
    CFG_MASK    = 4'd1,
    CFG_ROWS    = 4'd2,
    CFG_COLS    = 4'd3,
    CFG_ORG_ROW = 4'd4,
    CFG_ORG_COL = 4'd5,
    CFG_WIDTH   = 4'd6,
    CFG_HEIGHT  = 4'd7
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_DILATE = 2'd0,
    MODE_ERODE  = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_OPEN   = 2'd3
  } mode_e;

  typedef enum logic {
    KIND_DIL = 1'b0,
    KIND_ERO = 1'b1
  } kind_e;

  // per-step tags: jv = first-pass index in range, kv = output index in range
  typedef struct packed {
    logic jv;
    logic kv;
    logic last;
  } tag_t;

  typedef struct packed {
    logic pix;
    tag_t tag;
  } item_t;

  typedef struct packed {
    kind_e             kind;
    logic [DIM_W-1:0]  base_r;
    logic [DIM_W-1:0]  base_c;
    logic [MASK_W-1:0] mask;
  } stage_cfg_t;

  // Window setup for one pass. Tap (i,k) holds the pixel i lines and k
  // pixels back from the newest; it lands at (row+base_r-i, col+base_c-k).
  function automatic stage_cfg_t calc_stage_cfg(
    input logic              second,
    input mode_e             mode,
    input logic [MASK_W-1:0] se,
    input logic [DIM_W-1:0]  rows,
    input logic [DIM_W-1:0]  cols,
    input logic [DIM_W-1:0]  orr,
    input logic [DIM_W-1:0]  orc
  );
    stage_cfg_t sc;
    logic       pass;
    logic       ero;
    logic [DIM_W-1:0] rr;
    logic [DIM_W-1:0] rc;
    logic [4:0] idx;
    pass = second && (mode == MODE_DILATE || mode == MODE_ERODE);
    ero  = second ? (mode == MODE_CLOSE) : (mode == MODE_ERODE || mode == MODE_OPEN);
    sc.kind   = (ero && !pass) ? KIND_ERO : KIND_DIL;
    sc.base_r = '0;
    sc.base_c = '0;
    sc.mask   = '0;
    if (!pass) begin
      if (ero) begin
        sc.base_r = rows - DIM_W'(1) - orr;
        sc.base_c = cols - DIM_W'(1) - orc;
      end else begin
        sc.base_r = orr;
        sc.base_c = orc;
      end
    end
    for (int i = 0; i < SE_MAX; i++) begin
      for (int k = 0; k < SE_MAX; k++) begin
        rr  = rows - DIM_W'(1) - DIM_W'(i);
        rc  = cols - DIM_W'(1) - DIM_W'(k);
        idx = 5'(rr) * 5'(SE_MAX) + 5'(rc);
        if (pass) begin
          sc.mask[i*SE_MAX+k] = (i == 0) && (k == 0);
        end else if (ero) begin
          sc.mask[i*SE_MAX+k] =
            ((DIM_W'(i) < rows) && (DIM_W'(k) < cols) && se[idx]) ||
            ((DIM_W'(i) == sc.base_r) && (DIM_W'(k) == sc.base_c));
        end else begin
          sc.mask[i*SE_MAX+k] =
            (DIM_W'(i) < rows) && (DIM_W'(k) < cols) && se[i*SE_MAX+k];
        end
      end
    end
    return sc;
  endfunction

endpackage

// ===== rtl/bmf_ram.sv =====
module bmf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = bmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bmf_front.sv =====
module bmf_front #(
  parameter int SW = 21,
  parameter int NW = 21,
  parameter int LW = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  logic [NW-1:0]       n_pix,
  input  logic [LW-1:0]       lag1,
  input  logic [LW-1:0]       lagt,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic                in_pix,
  input  logic                q_ready,
  output logic                q_valid,
  output bmf_pkg::item_t      q_item
);

  logic [SW-1:0] step_r, step_nxt;
  logic          counted;
  logic          last;
  logic          fire;

  // pixels fill the frame first; after that every beat is a flush step
  assign counted = (step_r < SW'(n_pix)) ? (in_opcode == bmf_pkg::OP_PIXEL) : 1'b1;
  assign last    = step_r == SW'(n_pix) + SW'(lagt) - SW'(1);
  assign in_ready = q_ready;
  assign q_valid  = in_valid && counted;
  assign fire     = in_valid && q_ready && counted;

  always_comb begin
    q_item.pix      = in_pix;
    q_item.tag.jv   = step_r >= SW'(lag1);
    q_item.tag.kv   = step_r >= SW'(lagt);
    q_item.tag.last = last;
    step_nxt = step_r;
    if (clr) begin
      step_nxt = '0;
    end else if (fire) begin
      step_nxt = last ? '0 : step_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/bmf_queue.sv =====
module bmf_queue #(
  parameter int DEPTH = bmf_pkg::QDEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clr,
  input  logic           push_valid,
  output logic           push_ready,
  input  bmf_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bmf_pkg::item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  bmf_pkg::item_t  mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = cnt_r != CNTW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rp_r];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
    if (clr) begin
      wp_nxt  = '0;
      rp_nxt  = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/bmf_stage.sv =====
module bmf_stage #(
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clr,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height,
  input  bmf_pkg::stage_cfg_t                scfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_pix,
  input  logic                               in_adv,
  input  bmf_pkg::tag_t                      in_tag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_res,
  output bmf_pkg::tag_t                      out_tag
);

  localparam int SE = bmf_pkg::SE_MAX;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 9);

  logic [SE-1:0][SE-1:0] win_r, win_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [SE-2:0]         ram_q, rd, wdata;
  logic                  byp_r;
  logic [SE-2:0]         bdat_r;
  logic                  fresh_r, fresh_nxt;
  logic                  adv_r;
  bmf_pkg::tag_t         tag_r;
  logic [RW-1:0]         row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic                  fire, take;
  logic [RW:0]           sum_r;
  logic [CW:0]           sum_c;
  logic [SE-1:0]         row_ok, col_ok;
  logic [SE*SE-1:0]      hit;

  assign in_ready  = !fresh_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = fresh_r;
  assign take      = fresh_r && out_ready;
  assign out_tag   = tag_r;

  // line delay: one word per column, line i of the word feeds tap row i+1
  assign rd    = byp_r ? bdat_r : ram_q;
  assign wdata = {rd[SE-3:0], in_pix};

  always_comb begin
    ptr_nxt = ptr_r;
    if (clr) begin
      ptr_nxt = '0;
    end else if (fire) begin
      ptr_nxt = (CW'(ptr_r) == width - CW'(1)) ? '0 : ptr_r + AW'(1);
    end
  end

  bmf_ram #(
    .WIDTH (SE - 1),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (fire),
    .waddr (ptr_r),
    .wdata (wdata),
    .raddr (ptr_nxt),
    .rdata (ram_q)
  );

  always_comb begin
    win_nxt = win_r;
    if (fire) begin
      for (int i = 0; i < SE; i++) begin
        for (int k = SE - 1; k > 0; k--) begin
          win_nxt[i][k] = win_r[i][k-1];
        end
        win_nxt[i][0] = (i == 0) ? in_pix : rd[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_comb begin
    fresh_nxt = fresh_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (take) begin
      fresh_nxt = 1'b0;
      if (tag_r.last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (adv_r) begin
        if (col_r == width - CW'(1)) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
    if (fire) begin
      fresh_nxt = 1'b1;
    end
    if (clr) begin
      fresh_nxt = 1'b0;
      row_nxt   = '0;
      col_nxt   = '0;
    end
  end

  // bounds per tap row and column, then AND/OR over the masked taps
  always_comb begin
    sum_r = (RW+1)'(row_r) + (RW+1)'(scfg.base_r);
    sum_c = (CW+1)'(col_r) + (CW+1)'(scfg.base_c);
    for (int i = 0; i < SE; i++) begin
      row_ok[i] = (sum_r >= (RW+1)'(i)) && (sum_r < (RW+1)'(height) + (RW+1)'(i));
      col_ok[i] = (sum_c >= (CW+1)'(i)) && (sum_c < (CW+1)'(width) + (CW+1)'(i));
    end
    for (int i = 0; i < SE; i++) begin
      for (int k = 0; k < SE; k++) begin
        hit[i*SE+k] = row_ok[i] && col_ok[k] && win_r[i][k];
      end
    end
    if (scfg.kind == bmf_pkg::KIND_ERO) begin
      out_res = &(~scfg.mask | hit);
    end else begin
      out_res = |(scfg.mask & hit);
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    bdat_r <= wdata;
    if (fire) begin
      adv_r <= in_adv;
      tag_r <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      byp_r   <= 1'b0;
      fresh_r <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      ptr_r   <= ptr_nxt;
      byp_r   <= fire && (ptr_nxt == ptr_r);
      fresh_r <= fresh_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

// ===== rtl/binary_morphology_filter.sv =====
// Binary morphology filter: dilation, erosion, closing or opening of a binary
// raster image with a structuring element of up to 5x5 and a chosen origin.
// Input stream: one beat per pixel in raster order (tuser = 0), or a drain
// beat (tuser = 1). Drains count only once the whole frame is in; the frame
// is flushed by as many drain beats (or spill pixels) as the total window
// lag, i.e. for each pass, its window row offset times image width plus its column offset.
// Output stream: one beat per filtered pixel in raster order, tlast on the
// last pixel of the frame.
// Config port: write register index/data while the block is idle; any valid
// write restarts the frame. Indexes beyond the register list are ignored.
// Throughput: one beat per clock while the output is not stalled. A beat passes
// through the queue, the first-pass window and the second-pass window to the
// output register, and waits out the window lag counted in beats.
// Line delays sit in one RAM per pass; its registered read is addressed from
// the next column pointer, so back-to-back beats never stall.
// Reset: registers return to defaults (dilation, empty mask, 3x3, origin 1,1,
// 1024x1024), counters clear. No memory clearing pass: stale line data only
// ever lands outside the image and is masked.
// Output stall: a full output register backs up the passes and the 4-entry
// queue; in_tready drops only when that queue is full.
module binary_morphology_filter #(
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // data: [0] pixel_in
  input  logic [7:0]                      in_tdata,
  // user: [0] opcode
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // data: [0] pixel_out
  output logic [7:0]                      out_tdata,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DW = bmf_pkg::DIM_W;
  localparam int SZ = bmf_pkg::SIZE_W;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LW = $clog2(8 * MAX_WIDTH + 9);
  localparam int SW = $clog2(MAX_WIDTH * MAX_HEIGHT + 8 * MAX_WIDTH + 9);
  localparam int EW = (CW > SZ) ? CW : SZ;
  localparam int EH = (HW > SZ) ? HW : SZ;

  // config registers
  bmf_pkg::mode_e              mode_r;
  logic [bmf_pkg::MASK_W-1:0]  mask_r;
  logic [DW-1:0]               rows_r, cols_r, orr_r, orc_r;
  logic [SZ-1:0]               wid_r, hgt_r;
  logic                        clr;

  // clamped setup
  logic [DW-1:0]               rows_c, cols_c, orr_c, orc_c;
  logic [EW-1:0]               wid_e;
  logic [EH-1:0]               hgt_e;
  logic [CW-1:0]               w_c;
  logic [HW-1:0]               h_c;
  bmf_pkg::stage_cfg_t         scfg1_c, scfg2_c, scfg1_r, scfg2_r;
  logic [CW-1:0]               w_r;
  logic [HW-1:0]               h_r;
  logic [NW-1:0]               n_pix;
  logic [LW-1:0]               lag1, lag2, lagt;

  // datapath handshakes
  logic                        q_in_valid, q_in_ready;
  bmf_pkg::item_t              q_in_item, q_out_item;
  logic                        q_out_valid, q_out_ready;
  logic                        s1_valid, s1_ready, s1_res;
  bmf_pkg::tag_t               s1_tag;
  logic                        s2_valid, s2_ready, s2_res;
  bmf_pkg::tag_t               s2_tag;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_pix_r, out_last_r;
  logic                        s2_take;

  assign cfg_ready = 1'b1;
  assign clr = cfg_valid && (cfg_index <= bmf_pkg::CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bmf_pkg::MODE_DILATE;
      mask_r <= '0;
      rows_r <= DW'(3);
      cols_r <= DW'(3);
      orr_r  <= DW'(1);
      orc_r  <= DW'(1);
      wid_r  <= SZ'(1024);
      hgt_r  <= SZ'(1024);
    end else if (cfg_valid) begin
      case (cfg_index)
        bmf_pkg::CFG_MODE:    mode_r <= bmf_pkg::mode_e'(cfg_data[bmf_pkg::MODE_W-1:0]);
        bmf_pkg::CFG_MASK:    mask_r <= cfg_data[bmf_pkg::MASK_W-1:0];
        bmf_pkg::CFG_ROWS:    rows_r <= cfg_data[DW-1:0];
        bmf_pkg::CFG_COLS:    cols_r <= cfg_data[DW-1:0];
        bmf_pkg::CFG_ORG_ROW: orr_r  <= cfg_data[DW-1:0];
        bmf_pkg::CFG_ORG_COL: orc_r  <= cfg_data[DW-1:0];
        bmf_pkg::CFG_WIDTH:   wid_r  <= cfg_data[SZ-1:0];
        bmf_pkg::CFG_HEIGHT:  hgt_r  <= cfg_data[SZ-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes into range; origin clamps into the element
  always_comb begin
    rows_c = (rows_r == '0) ? DW'(1) :
             (rows_r > DW'(bmf_pkg::SE_MAX)) ? DW'(bmf_pkg::SE_MAX) : rows_r;
    cols_c = (cols_r == '0) ? DW'(1) :
             (cols_r > DW'(bmf_pkg::SE_MAX)) ? DW'(bmf_pkg::SE_MAX) : cols_r;
    orr_c  = (orr_r > rows_c - DW'(1)) ? rows_c - DW'(1) : orr_r;
    orc_c  = (orc_r > cols_c - DW'(1)) ? cols_c - DW'(1) : orc_r;
    wid_e  = EW'(wid_r);
    hgt_e  = EH'(hgt_r);
    w_c = (wid_e == '0) ? CW'(1) :
          (wid_e > EW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(wid_e);
    h_c = (hgt_e == '0) ? HW'(1) :
          (hgt_e > EH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(hgt_e);
    scfg1_c = bmf_pkg::calc_stage_cfg(1'b0, mode_r, mask_r, rows_c, cols_c, orr_c, orc_c);
    scfg2_c = bmf_pkg::calc_stage_cfg(1'b1, mode_r, mask_r, rows_c, cols_c, orr_c, orc_c);
    n_pix = NW'(w_c) * NW'(h_c);
    // lag of a pass: base lines times width plus base pixels
    lag1 = LW'(scfg1_c.base_r) * LW'(w_c) + LW'(scfg1_c.base_c);
    lag2 = LW'(scfg2_c.base_r) * LW'(w_c) + LW'(scfg2_c.base_c);
    lagt = lag1 + lag2;
  end

  // passes see the registered setup; an item passes through the queue before it gets there
  always_ff @(posedge clk) begin
    scfg1_r <= scfg1_c;
    scfg2_r <= scfg2_c;
    w_r     <= w_c;
    h_r     <= h_c;
  end

  bmf_front #(
    .SW (SW),
    .NW (NW),
    .LW (LW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .n_pix     (n_pix),
    .lag1      (lag1),
    .lagt      (lagt),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_opcode (in_tuser),
    .in_pix    (in_tdata[0]),
    .q_ready   (q_in_ready),
    .q_valid   (q_in_valid),
    .q_item    (q_in_item)
  );

  bmf_queue #(
    .DEPTH (bmf_pkg::QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (clr),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_item  (q_in_item),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_item   (q_out_item)
  );

  // first pass: input pixels
  bmf_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pass1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .width     (w_r),
    .height    (h_r),
    .scfg      (scfg1_r),
    .in_valid  (q_out_valid),
    .in_ready  (q_out_ready),
    .in_pix    (q_out_item.pix),
    .in_adv    (q_out_item.tag.jv),
    .in_tag    (q_out_item.tag),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_res   (s1_res),
    .out_tag   (s1_tag)
  );

  // second pass: intermediate image, or a straight copy for single ops
  bmf_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pass2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .width     (w_r),
    .height    (h_r),
    .scfg      (scfg2_r),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_pix    (s1_res),
    .in_adv    (s1_tag.kv),
    .in_tag    (s1_tag),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_res   (s2_res),
    .out_tag   (s2_tag)
  );

  // output register; steps before the first output are dropped here
  assign s2_ready = !out_valid_r || out_tready;
  assign s2_take  = s2_valid && s2_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_take && s2_tag.kv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (clr) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s2_tag.kv) begin
      out_pix_r  <= s2_res;
      out_last_r <= s2_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_pix_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== dv/bmf_checker.sv =====
module bmf_checker
  import bmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            out_tdata,
  input  logic                  out_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output logic                  frame_busy
);

  localparam int RING = SE_MAX * DEF_MAX_WIDTH;

  typedef struct {
    bit pix;
    bit last;
  } filt_pix_t;

  filt_pix_t         filtered_q[$];
  bit                raw_lines[RING];
  bit                mid_lines[RING];
  int unsigned       pix_taken;
  mode_e             mode_r;
  logic [MASK_W-1:0] mask_r;
  logic [DIM_W-1:0]  rows_r, cols_r, orr_r, orc_r;
  logic [SIZE_W-1:0] width_r, height_r;

  function automatic int clampv(int unsigned v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // pixels off the image read as zero
  function automatic bit img_at(bit mid, int r, int c, int w, int h);
    int idx;
    if (r < 0 || r >= h || c < 0 || c >= w) return 1'b0;
    idx = (r * w + c) % RING;
    return mid ? mid_lines[idx] : raw_lines[idx];
  endfunction

  function automatic bit window_op(kind_e kind, bit mid, int r, int c, int w, int h,
                                   int rows, int cols, int orr, int orc);
    bit acc;
    acc = (kind == KIND_ERO) ? img_at(mid, r, c, w, h) : 1'b0;
    for (int a = 0; a < rows; a++) begin
      for (int b = 0; b < cols; b++) begin
        if (mask_r[a*SE_MAX+b]) begin
          if (kind == KIND_DIL) acc |= img_at(mid, r - a + orr, c - b + orc, w, h);
          else acc &= img_at(mid, r + a - orr, c + b - orc, w, h);
        end
      end
    end
    return acc;
  endfunction

  function automatic longint stage_lag(kind_e kind, int w, int rows, int cols,
                                       int orr, int orc);
    if (kind == KIND_DIL) return longint'(orr) * w + orc;
    return longint'(rows - 1 - orr) * w + (cols - 1 - orc);
  endfunction

  task automatic take_beat(input logic op, input logic px);
    int     w, h, rows, cols, orr, orc;
    longint n, l1, l2, j, k;
    kind_e  k1, k2;
    bit     two, v;
    w    = clampv(32'(width_r), 1, DEF_MAX_WIDTH);
    h    = clampv(32'(height_r), 1, DEF_MAX_HEIGHT);
    rows = clampv(32'(rows_r), 1, SE_MAX);
    cols = clampv(32'(cols_r), 1, SE_MAX);
    orr  = clampv(32'(orr_r), 0, rows - 1);
    orc  = clampv(32'(orc_r), 0, cols - 1);
    n    = longint'(w) * h;
    k1   = (mode_r == MODE_DILATE || mode_r == MODE_CLOSE) ? KIND_DIL : KIND_ERO;
    k2   = (mode_r == MODE_CLOSE) ? KIND_ERO : KIND_DIL;
    two  = (mode_r == MODE_CLOSE || mode_r == MODE_OPEN);
    l1   = stage_lag(k1, w, rows, cols, orr, orc);
    l2   = two ? stage_lag(k2, w, rows, cols, orr, orc) : 0;
    // drains are ignored until the frame is in; later pixels act as drains
    if (pix_taken < n) begin
      if (op == OP_DRAIN) return;
      raw_lines[pix_taken % RING] = px;
    end
    pix_taken++;
    j = longint'(pix_taken) - 1 - l1;
    if (j >= 0 && j < n)
      mid_lines[j % RING] = window_op(k1, 1'b0, int'(j / w), int'(j % w), w, h,
                                      rows, cols, orr, orc);
    k = j - l2;
    if (k < 0 || k >= n) return;
    v = two ? window_op(k2, 1'b1, int'(k / w), int'(k % w), w, h, rows, cols, orr, orc)
            : mid_lines[k % RING];
    filtered_q.push_back('{pix: v, last: (k == n - 1)});
    if (k == n - 1) pix_taken = 0;
  endtask

  always @(posedge clk) begin
    filt_pix_t e;
    int        bad;
    bad = 0;
    if (!rst_n) begin
      filtered_q.delete();
      foreach (raw_lines[i]) begin
        raw_lines[i] = 1'b0;
        mid_lines[i] = 1'b0;
      end
      pix_taken = 0;
      mode_r    = MODE_DILATE;
      mask_r    = '0;
      rows_r    = 3'd3;
      cols_r    = 3'd3;
      orr_r     = 3'd1;
      orc_r     = 3'd1;
      width_r   = SIZE_W'(DEF_MAX_WIDTH);
      height_r  = SIZE_W'(DEF_MAX_HEIGHT);
      errors     <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output beat: pixel_out %0d frame_last %0d",
                 out_tdata, out_tlast);
          bad++;
        end else begin
          e = filtered_q.pop_front();
          if (out_tdata !== {7'b0, e.pix}) begin
            $error("pixel_out: expected %0d, got %0d", e.pix, out_tdata);
            bad++;
          end
          if (out_tlast !== e.last) begin
            $error("frame_last: expected %0d, got %0d", e.last, out_tlast);
            bad++;
          end
        end
      end
      errors <= errors + bad;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= CFG_HEIGHT) pix_taken = 0;  // any valid write restarts
        case (cfg_index)
          CFG_MODE:    mode_r   = mode_e'(cfg_data[MODE_W-1:0]);
          CFG_MASK:    mask_r   = cfg_data[MASK_W-1:0];
          CFG_ROWS:    rows_r   = cfg_data[DIM_W-1:0];
          CFG_COLS:    cols_r   = cfg_data[DIM_W-1:0];
          CFG_ORG_ROW: orr_r    = cfg_data[DIM_W-1:0];
          CFG_ORG_COL: orc_r    = cfg_data[DIM_W-1:0];
          CFG_WIDTH:   width_r  = cfg_data[SIZE_W-1:0];
          CFG_HEIGHT:  height_r = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_beat(in_tuser, in_tdata[0]);
    end
    pending    <= filtered_q.size();
    frame_busy <= (pix_taken != 0);
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import bmf_pkg::*;

  localparam int PIX_BUDGET = 160;
  localparam int CYCLE_CAP  = 3000000;

  logic                  clk;
  logic                  rst_n;
  logic [7:0]            in_tdata;
  logic                  in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    errors;
  int                    pending;
  logic                  frame_busy;

  // raw size registers as written, used to know how many pixels make a frame
  logic [SIZE_W-1:0]     width_sh  = SIZE_W'(DEF_MAX_WIDTH);
  logic [SIZE_W-1:0]     height_sh = SIZE_W'(DEF_MAX_HEIGHT);
  bit                    calm;       // no gaps or stalls this phase
  int                    pix_sent;
  int                    stall_left;
  int                    cycles;

  binary_morphology_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bmf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .frame_busy (frame_busy)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, generous against the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("binary_morphology_filter: mismatch");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output-side backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  function automatic int clamp_size(logic [SIZE_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // one input beat; valid is left high so the next beat can follow at once
  task automatic send_beat(logic op, logic px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_WIDTH)  width_sh  = d[SIZE_W-1:0];
    if (idx == CFG_HEIGHT) height_sh = d[SIZE_W-1:0];
  endtask

  // all results in, then a margin for a beat still in the pipe
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_all(mode_e m, logic [MASK_W-1:0] mask, int rows, int cols,
                           int orr, int orc, int w, int h);
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_MASK, CFG_DATA_W'(mask));
    write_reg(CFG_ROWS, CFG_DATA_W'(rows));
    write_reg(CFG_COLS, CFG_DATA_W'(cols));
    write_reg(CFG_ORG_ROW, CFG_DATA_W'(orr));
    write_reg(CFG_ORG_COL, CFG_DATA_W'(orc));
    write_reg(CFG_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
  endtask

  // one full frame: pixels of given density (percent), stray drains mid-frame,
  // then drains and spill pixels until the frame closes
  task automatic run_frame(int density);
    int n;
    n = clamp_size(width_sh, DEF_MAX_WIDTH) * clamp_size(height_sh, DEF_MAX_HEIGHT);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) send_beat(OP_DRAIN, 1'($urandom_range(0, 1)));
      send_beat(OP_PIXEL, $urandom_range(0, 99) < density);
      pix_sent++;
    end
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (frame_busy) begin
      if ($urandom_range(0, 99) < 25) send_beat(OP_PIXEL, 1'($urandom_range(0, 1)));
      else send_beat(OP_DRAIN, 1'($urandom_range(0, 1)));
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_frames(int count);
    for (int f = 0; f < count; f++) run_frame(int'($urandom_range(0, 2)) * 45 + 5);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = OP_PIXEL;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data  = '0;
    cycles    = 0;
    stall_left = 0;
    pix_sent  = 0;
    calm      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full element, extreme origins, clamped sizes, empty mask
    write_all(MODE_DILATE, {MASK_W{1'b1}}, 5, 5, 2, 2, 4, 3);
    write_reg(CFG_IDX_W'(CFG_HEIGHT + 1), {CFG_DATA_W{1'b1}});    // unused index
    send_beat(OP_DRAIN, 1'b1);                        // idle drain
    run_frame(10);
    settle();
    write_all(MODE_ERODE, {MASK_W{1'b1}}, 5, 5, 4, 4, 3, 2);
    run_frame(100);
    settle();
    write_all(MODE_CLOSE, 25'h1, 0, 7, 7, 7, 0, 3);
    run_frame(50);
    settle();
    write_all(MODE_OPEN, '0, 1, 3, 0, 0, 4, 0);
    run_frame(50);
    settle();

    // random phases, each rewriting a random subset of the registers
    while (pix_sent < PIX_BUDGET) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0: write_reg(CFG_MASK, CFG_DATA_W'($urandom & {MASK_W{1'b1}}));
          1: write_reg(CFG_MASK, CFG_DATA_W'($urandom & $urandom & {MASK_W{1'b1}}));
          2: write_reg(CFG_MASK, CFG_DATA_W'(($urandom | $urandom) & {MASK_W{1'b1}}));
          default: write_reg(CFG_MASK, CFG_DATA_W'(1) << $urandom_range(0, MASK_W - 1));
        endcase
      end
      if ($urandom_range(0, 1)) write_reg(CFG_ROWS, CFG_DATA_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 1)) write_reg(CFG_COLS, CFG_DATA_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 1)) write_reg(CFG_ORG_ROW, CFG_DATA_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 1)) write_reg(CFG_ORG_COL, CFG_DATA_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_IDX_W'(CFG_HEIGHT + $urandom_range(1, 8)), CFG_DATA_W'($urandom));
      // keep frames small; the size regs still reset to 1024x1024
      if ($urandom_range(0, 1) || width_sh > 12)
        write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(0, 12)));
      if ($urandom_range(0, 1) || height_sh > 10)
        write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(0, 10)));
      run_frames(int'($urandom_range(1, 3)));
      settle();
    end

    // widest image with the width clamped; one element row keeps the lag short
    calm = 1'b0;
    write_all(mode_e'($urandom_range(0, 3)), MASK_W'($urandom), 1, 7, 7, 7, 2047, 1);
    run_frame(50);

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("binary_morphology_filter: match");
    end else begin
      $display("binary_morphology_filter: mismatch");
    end
    $finish;
  end

endmodule
